// ----- sv/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types and constants for the min-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int HEAP_DEPTH  = 64;
    localparam int TIME_BITS   = 32;
    localparam int KIND_BITS   = 8;
    localparam int CAP_BITS    = 7;
    localparam int STATUS_BITS = 2;

    localparam int ADDR_BITS = $clog2(HEAP_DEPTH);
    localparam int CNT_BITS  = $clog2(HEAP_DEPTH + 1);
    localparam int LIM_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    localparam int IN_DATA_BITS  = ((TIME_BITS + KIND_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((TIME_BITS + KIND_BITS + CNT_BITS + 7) / 8) * 8;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic [KIND_BITS-1:0] tag;
        logic [TIME_BITS-1:0] tkey;
    } heap_entry_t;

    localparam int ENTRY_BITS = $bits(heap_entry_t);

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_REMOVED  = 2'd2,
        STAT_EMPTY    = 2'd3
    } mhpq_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROOT,
        ST_UP,
        ST_DOWN,
        ST_PLACE,
        ST_DONE
    } mhpq_state_t;

endpackage

// ----- sv/mhpq_ram.sv -----
// ----------------------------------------------------------------------------
// mhpq_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- sv/min_heap_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// binary min-heap of timed events held in one ram, one request per beat
// ----------------------------------------------------------------------------
// Each input beat is one request and gives exactly one result beat. Requests
// are handled one at a time. An insert walks START, one UP step per level the
// new entry climbs, PLACE if it reaches the root, then DONE; a removal walks
// START, ROOT, one DOWN step per level the last entry sinks, PLACE if it
// reaches a leaf, then DONE. DONE registers the result once the output register
// is free or being taken, and the next request is taken after that. The walk
// does one compare against the parent or the smaller child and one ram write per
// level, with both children fetched together on the ram's two read ports. A
// finished result waits in the output register while the next request is taken.
// Refused inserts, removals from an empty heap and inserts into an empty heap go
// from START straight to DONE, a removal that leaves at most one entry from ROOT.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mhpq_pkg::CAP_BITS-1:0]       cfg_data,      // capacity_limit
    // request beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mhpq_pkg::IN_DATA_BITS-1:0]   s_tdata,       // event_time, event_kind
    input  logic                                s_tuser,       // req_type
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mhpq_pkg::OUT_DATA_BITS-1:0]  m_tdata,       // out_time, out_kind,
                                                               // entry_count, zero pad
    output logic [mhpq_pkg::STATUS_BITS-1:0]    m_tuser        // status
);

    import mhpq_pkg::*;

    mhpq_state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]    occ_reg, occ_next;
    logic [CAP_BITS-1:0]    cap_reg, cap_next;
    logic [CNT_BITS-1:0]    idx_reg, idx_next;
    logic                   req_reg, req_next;
    heap_entry_t            item_reg, item_next;
    heap_entry_t            res_reg, res_next;
    mhpq_status_t           stat_reg, stat_next;

    logic                   out_valid_reg, out_valid_next;
    mhpq_status_t           out_stat_reg, out_stat_next;
    heap_entry_t            out_res_reg, out_res_next;
    logic [CNT_BITS-1:0]    out_cnt_reg, out_cnt_next;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_wa;
    heap_entry_t            ram_wd;
    logic [ADDR_BITS-1:0]   ram_ra;
    logic [ADDR_BITS-1:0]   ram_rb;
    logic [ENTRY_BITS-1:0]  ram_qa;
    logic [ENTRY_BITS-1:0]  ram_qb;

    heap_entry_t            rd_a;
    heap_entry_t            rd_b;
    logic                   full;
    logic [CNT_BITS-1:0]    parent;
    logic [CNT_BITS-1:0]    child_base;
    logic [CNT_BITS-1:0]    child;
    logic                   pick_right;
    heap_entry_t            child_entry;
    logic [CNT_BITS:0]      child_dbl;

    mhpq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_wa),
        .wdata   (ram_wd),
        .raddr_a (ram_ra),
        .rdata_a (ram_qa),
        .raddr_b (ram_rb),
        .rdata_b (ram_qb)
    );

    assign rd_a = heap_entry_t'(ram_qa);
    assign rd_b = heap_entry_t'(ram_qb);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_stat_reg;
    assign m_tdata   = OUT_DATA_BITS'({out_cnt_reg, out_res_reg.tag, out_res_reg.tkey});

    // full when occupancy reaches the smaller of the limit and the depth
    assign full = (LIM_BITS'(occ_reg) >= LIM_BITS'(cap_reg))
               || (occ_reg >= CNT_BITS'(HEAP_DEPTH));

    assign parent      = idx_reg >> 1;
    assign child_base  = CNT_BITS'({idx_reg, 1'b0});
    assign pick_right  = (child_base != occ_reg) && (rd_b.tkey < rd_a.tkey);
    assign child       = pick_right ? child_base + CNT_BITS'(1) : child_base;
    assign child_entry = pick_right ? rd_b : rd_a;
    assign child_dbl   = {child, 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cap_next       = cap_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_res_next   = out_res_reg;
        out_cnt_next   = out_cnt_reg;
        ram_we         = 1'b0;
        ram_wa         = ADDR_BITS'(idx_reg - CNT_BITS'(1));
        ram_wd         = item_reg;
        ram_ra         = '0;
        ram_rb         = '0;

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next       = s_tuser;
                    item_next.tkey = s_tdata[TIME_BITS-1:0];
                    item_next.tag  = s_tdata[TIME_BITS+KIND_BITS-1:TIME_BITS];
                    state_next     = ST_START;
                end
            end

            ST_START:
            begin
                res_next = '0;
                if (req_reg == REQ_INSERT)
                begin
                    if (full)
                    begin
                        stat_next  = STAT_FULL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        stat_next = STAT_INSERTED;
                        occ_next  = occ_reg + CNT_BITS'(1);
                        idx_next  = occ_reg + CNT_BITS'(1);
                        if (occ_reg == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_wa     = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ram_ra     = ADDR_BITS'(((occ_reg + CNT_BITS'(1)) >> 1)
                                                    - CNT_BITS'(1));
                            state_next = ST_UP;
                        end
                    end
                end
                else
                begin
                    if (occ_reg == '0)
                    begin
                        stat_next  = STAT_EMPTY;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        stat_next  = STAT_REMOVED;
                        occ_next   = occ_reg - CNT_BITS'(1);
                        ram_ra     = '0;
                        ram_rb     = ADDR_BITS'(occ_reg - CNT_BITS'(1));
                        state_next = ST_ROOT;
                    end
                end
            end

            ST_ROOT:
            begin
                // root leaves, last entry sinks from the top
                res_next  = rd_a;
                item_next = rd_b;
                idx_next  = CNT_BITS'(1);
                if (occ_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (occ_reg == CNT_BITS'(1))
                begin
                    ram_we     = 1'b1;
                    ram_wa     = '0;
                    ram_wd     = rd_b;
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_ra     = ADDR_BITS'(1);
                    ram_rb     = ADDR_BITS'(2);
                    state_next = ST_DOWN;
                end
            end

            ST_UP:
            begin
                ram_we = 1'b1;
                if (item_reg.tkey < rd_a.tkey)
                begin
                    ram_wd   = rd_a;
                    idx_next = parent;
                    if (parent > CNT_BITS'(1))
                    begin
                        ram_ra     = ADDR_BITS'((parent >> 1) - CNT_BITS'(1));
                        state_next = ST_UP;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DOWN:
            begin
                ram_we = 1'b1;
                if (item_reg.tkey > child_entry.tkey)
                begin
                    ram_wd   = child_entry;
                    idx_next = child;
                    if (child_dbl <= {1'b0, occ_reg})
                    begin
                        ram_ra     = ADDR_BITS'(child_dbl - (CNT_BITS+1)'(1));
                        ram_rb     = ADDR_BITS'(child_dbl);
                        state_next = ST_DOWN;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_PLACE:
            begin
                ram_we     = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_res_next   = res_reg;
                    out_cnt_next   = occ_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        out_stat_reg <= out_stat_next;
        out_res_reg  <= out_res_next;
        out_cnt_reg  <= out_cnt_next;
    end

endmodule
